// File: rtl/ftpc_pkg.sv
// Shared types and constants for the fuel transfer pump controller.
`default_nettype none
package ftpc_pkg;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP  = 2'd2;

  localparam logic [CNT_W-1:0] PRESS_RST   = 10'd10;
  localparam logic [CNT_W-1:0] RELEASE_RST = 10'd15;
  localparam logic [CNT_W-1:0] WARMUP_RST  = 10'd51;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_NONE  = 2'b00;
  localparam logic [1:0] CMD_START = 2'b01;
  localparam logic [1:0] CMD_STOP  = 2'b10;

  typedef enum logic [1:0] {
    ST_READY  = 2'd0,
    ST_REF_TR = 2'd1,
    ST_REF_CH = 2'd2,
    ST_MANUAL = 2'd3
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_TR  = 2'd1,
    MODE_CH  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_HOLD    = 2'd1,
    EV_RELEASE = 2'd2
  } btn_event_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic       active;
    mode_t      mode;
    btn_event_t ev;
    logic       main_low;
    logic       main_high;
    logic       chassis_low;
    logic       sens_err;
    logic       tr_ok;
    logic       ch_ok;
    logic       tr_fault;
    logic       ch_fault;
  } tick_t;

endpackage
`default_nettype wire

// File: rtl/ftpc_in_if.sv
// Input tick channel interface.
`default_nettype none
interface ftpc_in_if;
  logic valid;
  logic ready;
  logic switch_transfer;
  logic switch_chassis;
  logic button_level;
  logic main_low_quarter;
  logic main_high_ninety;
  logic chassis_low_quarter;
  logic main_sensor_error;
  logic transfer_start_ok;
  logic chassis_start_ok;
  logic transfer_fault;
  logic chassis_fault;

  modport source (
    output valid, switch_transfer, switch_chassis, button_level, main_low_quarter,
           main_high_ninety, chassis_low_quarter, main_sensor_error, transfer_start_ok,
           chassis_start_ok, transfer_fault, chassis_fault,
    input  ready
  );
  modport sink (
    input  valid, switch_transfer, switch_chassis, button_level, main_low_quarter,
           main_high_ninety, chassis_low_quarter, main_sensor_error, transfer_start_ok,
           chassis_start_ok, transfer_fault, chassis_fault,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/ftpc_out_if.sv
// Result channel interface.
`default_nettype none
interface ftpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] control_state;
  logic [1:0] selected_mode;
  logic [1:0] button_event;
  logic [1:0] transfer_command;
  logic [1:0] chassis_command;

  modport source (
    output valid, control_state, selected_mode, button_event, transfer_command,
           chassis_command,
    input  ready
  );
  modport sink (
    input  valid, control_state, selected_mode, button_event, transfer_command,
           chassis_command,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/ftpc_cfg_if.sv
// Configuration write channel interface.
`default_nettype none
interface ftpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ftpc_pkg::CFG_IDX_W-1:0]  index;
  logic [ftpc_pkg::CNT_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/ftpc_front.sv
// Front end: config registers, button qualifier, warm-up count, mode decode.
`default_nettype none
module ftpc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  ftpc_in_if.sink              in_ch,
  ftpc_cfg_if.sink             cfg_ch,
  input  wire logic            q_full,
  output ftpc_pkg::tick_t      push_tick,
  output logic                 push
);

  logic [ftpc_pkg::CNT_W-1:0] press_ticks_r, release_ticks_r, warmup_ticks_r;
  logic                       phase_r, phase_nxt;
  logic [ftpc_pkg::CNT_W-1:0] bcnt_r, bcnt_nxt, bcnt_up;
  logic [ftpc_pkg::CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic                       pressed, active;
  ftpc_pkg::btn_event_t       ev;
  ftpc_pkg::mode_t            mode;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign push         = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= ftpc_pkg::PRESS_RST;
      release_ticks_r <= ftpc_pkg::RELEASE_RST;
      warmup_ticks_r  <= ftpc_pkg::WARMUP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ftpc_pkg::CFG_PRESS:   press_ticks_r   <= cfg_ch.data;
        ftpc_pkg::CFG_RELEASE: release_ticks_r <= cfg_ch.data;
        ftpc_pkg::CFG_WARMUP:  warmup_ticks_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign pressed = !in_ch.button_level;
  assign bcnt_up = (bcnt_r == ftpc_pkg::CNT_MAX) ? bcnt_r : bcnt_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    ev        = ftpc_pkg::EV_NONE;
    if (!phase_r) begin
      bcnt_nxt = pressed ? bcnt_up : '0;
      if (bcnt_nxt >= press_ticks_r) begin
        phase_nxt = 1'b1;
        bcnt_nxt  = '0;
        ev        = ftpc_pkg::EV_HOLD;
      end
    end else begin
      ev = ftpc_pkg::EV_HOLD;
      if (!pressed) begin
        bcnt_nxt = bcnt_up;
        if (bcnt_nxt >= release_ticks_r) begin
          phase_nxt = 1'b0;
          bcnt_nxt  = '0;
          ev        = ftpc_pkg::EV_RELEASE;
        end
      end
    end
  end

  assign active   = (wcnt_r >= warmup_ticks_r);
  assign wcnt_nxt = (!active && wcnt_r != ftpc_pkg::CNT_MAX) ? wcnt_r + 1'b1 : wcnt_r;

  assign mode = in_ch.switch_transfer ? ftpc_pkg::MODE_TR :
                in_ch.switch_chassis  ? ftpc_pkg::MODE_CH : ftpc_pkg::MODE_OFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      bcnt_r  <= '0;
      wcnt_r  <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_comb begin
    push_tick.active      = active;
    push_tick.mode        = mode;
    push_tick.ev          = ev;
    push_tick.main_low    = in_ch.main_low_quarter;
    push_tick.main_high   = in_ch.main_high_ninety;
    push_tick.chassis_low = in_ch.chassis_low_quarter;
    push_tick.sens_err    = in_ch.main_sensor_error;
    push_tick.tr_ok       = in_ch.transfer_start_ok;
    push_tick.ch_ok       = in_ch.chassis_start_ok;
    push_tick.tr_fault    = in_ch.transfer_fault;
    push_tick.ch_fault    = in_ch.chassis_fault;
  end

endmodule
`default_nettype wire

// File: rtl/ftpc_queue.sv
// Short FIFO of classified ticks between front and back.
`default_nettype none
module ftpc_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ftpc_pkg::tick_t  push_tick,
  output logic                  full,
  output logic                  head_valid,
  output ftpc_pkg::tick_t       head_tick,
  input  wire logic             pop
);

  ftpc_pkg::tick_t                mem [ftpc_pkg::QDEPTH];
  logic [ftpc_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [ftpc_pkg::QCNT_W-1:0]    cnt_r;

  assign full       = (cnt_r == ftpc_pkg::QCNT_W'(ftpc_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_tick  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == ftpc_pkg::QPTR_W'(ftpc_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == ftpc_pkg::QPTR_W'(ftpc_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ftpc_back.sv
// Back end: refuel state machine, pump commands and result register.
`default_nettype none
module ftpc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire ftpc_pkg::tick_t  head_tick,
  output logic                  pop,
  ftpc_out_if.source            out_ch
);

  ftpc_pkg::ctrl_state_t state_r, state_nxt, st_eff;
  ftpc_pkg::mode_t       mode_r, mode_nxt;
  logic                  mode_chg;
  logic [1:0]            tr_cmd, ch_cmd;
  logic                  go_refuel;
  ftpc_pkg::tick_t       t;

  logic                  out_valid_r;
  ftpc_pkg::ctrl_state_t out_state_r;
  ftpc_pkg::mode_t       out_mode_r;
  ftpc_pkg::btn_event_t  out_ev_r;
  logic [1:0]            out_tr_r, out_ch_r;

  assign t   = head_tick;
  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  assign mode_chg  = t.active && (t.mode != mode_r);
  assign st_eff    = mode_chg ? ftpc_pkg::ST_READY : state_r;
  assign mode_nxt  = t.active ? t.mode : mode_r;
  assign go_refuel = (t.ev == ftpc_pkg::EV_RELEASE || t.main_low) &&
                     t.mode != ftpc_pkg::MODE_OFF && !t.sens_err;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (t.active) begin
      state_nxt = st_eff;
      unique case (st_eff)
        ftpc_pkg::ST_READY: begin
          if (go_refuel) begin
            if (t.mode == ftpc_pkg::MODE_TR) begin
              if (t.tr_ok) state_nxt = ftpc_pkg::ST_REF_TR;
            end else if (!t.chassis_low && t.ch_ok) begin
              state_nxt = ftpc_pkg::ST_REF_CH;
            end
          end else if (t.ev != ftpc_pkg::EV_NONE && t.sens_err) begin
            state_nxt = ftpc_pkg::ST_MANUAL;
          end
        end
        ftpc_pkg::ST_REF_TR: begin
          if (t.ev == ftpc_pkg::EV_RELEASE || t.main_high || t.tr_fault) begin
            state_nxt = ftpc_pkg::ST_READY;
          end
        end
        ftpc_pkg::ST_REF_CH: begin
          if (t.ev == ftpc_pkg::EV_RELEASE || t.main_high || t.chassis_low || t.ch_fault) begin
            state_nxt = ftpc_pkg::ST_READY;
          end
        end
        ftpc_pkg::ST_MANUAL: begin
          if (t.ev != ftpc_pkg::EV_HOLD) state_nxt = ftpc_pkg::ST_READY;
        end
      endcase
    end
  end

  // pump commands
  always_comb begin
    tr_cmd = ftpc_pkg::CMD_NONE;
    ch_cmd = ftpc_pkg::CMD_NONE;
    if (t.active) begin
      if (mode_chg) begin
        tr_cmd = ftpc_pkg::CMD_STOP;
        ch_cmd = ftpc_pkg::CMD_STOP;
      end
      unique case (st_eff)
        ftpc_pkg::ST_READY: begin
          if (go_refuel) begin
            if (t.mode == ftpc_pkg::MODE_TR) tr_cmd = tr_cmd | ftpc_pkg::CMD_START;
            else if (!t.chassis_low) ch_cmd = ch_cmd | ftpc_pkg::CMD_START;
          end else if (t.ev != ftpc_pkg::EV_NONE && t.sens_err) begin
            if (t.mode == ftpc_pkg::MODE_TR) tr_cmd = tr_cmd | ftpc_pkg::CMD_START;
            else if (t.mode == ftpc_pkg::MODE_CH) ch_cmd = ch_cmd | ftpc_pkg::CMD_START;
          end
        end
        ftpc_pkg::ST_REF_TR: begin
          if (t.ev == ftpc_pkg::EV_RELEASE || t.main_high) begin
            tr_cmd = tr_cmd | ftpc_pkg::CMD_STOP;
          end
        end
        ftpc_pkg::ST_REF_CH: begin
          if (t.ev == ftpc_pkg::EV_RELEASE || t.main_high || t.chassis_low) begin
            ch_cmd = ch_cmd | ftpc_pkg::CMD_STOP;
          end
        end
        ftpc_pkg::ST_MANUAL: begin
          if (t.ev != ftpc_pkg::EV_HOLD) begin
            if (t.mode == ftpc_pkg::MODE_TR) tr_cmd = tr_cmd | ftpc_pkg::CMD_STOP;
            else if (t.mode == ftpc_pkg::MODE_CH) ch_cmd = ch_cmd | ftpc_pkg::CMD_STOP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftpc_pkg::ST_READY;
      mode_r      <= ftpc_pkg::MODE_OFF;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        state_r     <= state_nxt;
        mode_r      <= mode_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_state_r <= state_nxt;
      out_mode_r  <= t.mode;
      out_ev_r    <= t.ev;
      out_tr_r    <= tr_cmd;
      out_ch_r    <= ch_cmd;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.control_state    = out_state_r;
  assign out_ch.selected_mode    = out_mode_r;
  assign out_ch.button_event     = out_ev_r;
  assign out_ch.transfer_command = out_tr_r;
  assign out_ch.chassis_command  = out_ch_r;

endmodule
`default_nettype wire

// File: rtl/fuel_transfer_pump_controller.sv
// Top level: front classifier, tick queue and refuel back end.
// An accepted tick is written into the two-entry queue, which absorbs output
// stalls, and is then popped into the result register that drives out valid.
// Throughput: one tick per cycle while the queue is not full; the back end
// retires one queued tick per cycle into the result register unless stalled.
// Reset: synchronous, active low; config returns to 10/15/51 and all state
// to ready/off with counts cleared, no clearing pass.
`default_nettype none
module fuel_transfer_pump_controller (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ftpc_in_if.sink    in_ch,
  ftpc_out_if.source out_ch,
  ftpc_cfg_if.sink   cfg_ch
);

  ftpc_pkg::tick_t push_tick, head_tick;
  logic            push, q_full, head_valid, pop;

  ftpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push_tick (push_tick),
    .push      (push)
  );

  ftpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tick  (push_tick),
    .full       (q_full),
    .head_valid (head_valid),
    .head_tick  (head_tick),
    .pop        (pop)
  );

  ftpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_tick  (head_tick),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
